### src/oil_pkg.sv
// ----------------------------------------------------------------------------
// oil_pkg
// shared types and fixed field widths of the ordered item list
// ----------------------------------------------------------------------------
package oil_pkg;

    localparam int REQ_W    = 3;
    localparam int IN_ITEM_W = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 4;
    localparam int CNT_W    = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH       = 3'd0,
        REQ_POP        = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_REMOVE_ALL = 3'd3,
        REQ_REMOVE_AT  = 3'd4,
        REQ_FIND       = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_TAIL = 2'd2,
        S_DONE = 2'd3
    } t_state;

endpackage

### src/ordered_item_list_top.sv
// ----------------------------------------------------------------------------
// ordered_item_list_top
// ordered list of item words kept in a slot memory with a live count
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_req_type i_item_value i_position
//  result    out        o_valid / i_ready   o_status o_item_out o_found
//                                           o_found_position o_count_out
//
// one request at a time; a request walks n slots (n from one to
// MAX_ENTRIES), limited by the single read and write port of the slot memory,
// which the walk uses once per cycle each; push and insert add a tail write
// after the walk; push and insert at the end walk no slots, nor does remove at
// the last entry; failed checks and unknown requests skip the walk
// reset clears the live count and the control state; the slot memory is not cleared
// a stalled result waits in the output register while the next request runs
// ----------------------------------------------------------------------------
module ordered_item_list_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int ITEM_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [oil_pkg::REQ_W-1:0]      i_req_type,
    input  logic [oil_pkg::IN_ITEM_W-1:0]  i_item_value,
    input  logic [oil_pkg::POS_W-1:0]      i_position,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [oil_pkg::STATUS_W-1:0]   o_status,
    output logic [oil_pkg::IN_ITEM_W-1:0]  o_item_out,
    output logic                           o_found,
    output logic [oil_pkg::FPOS_W-1:0]     o_found_position,
    output logic [oil_pkg::CNT_W-1:0]      o_count_out
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > oil_pkg::POS_W) ? CW : oil_pkg::POS_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    oil_pkg::t_state  r_state, n_state;
    oil_pkg::t_req    r_op, n_op;
    oil_pkg::t_status r_st, n_st;
    logic [ITEM_WIDTH-1:0] r_val, n_val;
    logic [ITEM_WIDTH-1:0] r_item, n_item;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_rd_idx, n_rd_idx;
    logic [CW-1:0]         r_left, n_left;
    logic [CW-1:0]         r_pend_idx, n_pend_idx;
    logic [CW-1:0]         r_keep, n_keep;
    logic                  r_pend, n_pend;
    logic                  r_fnd, n_fnd;
    logic [CW-1:0]         r_fpos, n_fpos;

    logic                          r_ov, n_ov;
    oil_pkg::t_status              r_o_status, n_o_status;
    logic [ITEM_WIDTH-1:0]         r_o_item, n_o_item;
    logic                          r_o_found, n_o_found;
    logic [CW-1:0]                 r_o_fpos, n_o_fpos;
    logic [CW-1:0]                 r_o_count, n_o_count;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ITEM_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [ITEM_WIDTH-1:0] mem_rdata;

    logic [oil_pkg::IN_ITEM_W+ITEM_WIDTH-1:0] in_ext;
    logic [oil_pkg::IN_ITEM_W+ITEM_WIDTH-1:0] out_ext;
    logic [CW+oil_pkg::FPOS_W-1:0]            fpos_ext;
    logic [CW+oil_pkg::CNT_W-1:0]             cnt_ext;
    logic [ITEM_WIDTH-1:0] in_val;
    logic [CMPW-1:0]       pos_cmp;
    logic [CMPW-1:0]       cnt_cmp;
    logic [CW-1:0]         in_pos;
    logic                  walk_down;
    oil_pkg::t_req         in_req;

    assign in_ext  = {{ITEM_WIDTH{1'b0}}, i_item_value};
    assign in_val  = in_ext[ITEM_WIDTH-1:0];
    assign pos_cmp = CMPW'(i_position);
    assign cnt_cmp = CMPW'(r_cnt);
    assign in_pos  = pos_cmp[CW-1:0];
    assign in_req  = oil_pkg::t_req'(i_req_type);
    assign walk_down = (r_op == oil_pkg::REQ_PUSH) || (r_op == oil_pkg::REQ_POP) ||
                       (r_op == oil_pkg::REQ_INSERT);

    oil_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ITEM_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oil_pkg::S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_left  <= n_left;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_st       <= n_st;
        r_val      <= n_val;
        r_item     <= n_item;
        r_pos      <= n_pos;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_keep     <= n_keep;
        r_fnd      <= n_fnd;
        r_fpos     <= n_fpos;
        r_o_status <= n_o_status;
        r_o_item   <= n_o_item;
        r_o_found  <= n_o_found;
        r_o_fpos   <= n_o_fpos;
        r_o_count  <= n_o_count;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_st       = r_st;
        n_val      = r_val;
        n_item     = r_item;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_rd_idx   = r_rd_idx;
        n_left     = r_left;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_keep     = r_keep;
        n_fnd      = r_fnd;
        n_fpos     = r_fpos;
        n_ov       = r_ov && !i_ready;
        n_o_status = r_o_status;
        n_o_item   = r_o_item;
        n_o_found  = r_o_found;
        n_o_fpos   = r_o_fpos;
        n_o_count  = r_o_count;
        mem_we     = 1'b0;
        mem_waddr  = r_pos[AW-1:0];
        mem_wdata  = r_val;
        mem_re     = 1'b0;
        mem_raddr  = r_rd_idx[AW-1:0];
        o_ready    = (r_state == oil_pkg::S_IDLE);

        case (r_state)
            oil_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op     = in_req;
                    n_val    = in_val;
                    n_pos    = in_pos;
                    n_st     = oil_pkg::ST_OK;
                    n_item   = '0;
                    n_fnd    = 1'b0;
                    n_fpos   = '0;
                    n_pend   = 1'b0;
                    n_keep   = '0;
                    n_left   = '0;
                    n_rd_idx = r_cnt - ONE_C;
                    n_state  = oil_pkg::S_WALK;
                    case (in_req)
                        oil_pkg::REQ_PUSH: begin
                            n_pos = r_cnt;
                            if (r_cnt == MAX_C) begin
                                n_st    = oil_pkg::ST_FULL;
                                n_state = oil_pkg::S_DONE;
                            end
                        end
                        oil_pkg::REQ_POP: begin
                            n_left = ONE_C;
                            if (r_cnt == '0) begin
                                n_st    = oil_pkg::ST_RANGE;
                                n_state = oil_pkg::S_DONE;
                            end
                        end
                        oil_pkg::REQ_INSERT: begin
                            n_left = r_cnt - in_pos;
                            if (pos_cmp > cnt_cmp) begin
                                n_st    = oil_pkg::ST_RANGE;
                                n_state = oil_pkg::S_DONE;
                            end else if (r_cnt == MAX_C) begin
                                n_st    = oil_pkg::ST_FULL;
                                n_state = oil_pkg::S_DONE;
                            end
                        end
                        oil_pkg::REQ_REMOVE_ALL: begin
                            n_rd_idx = '0;
                            n_left   = r_cnt;
                        end
                        oil_pkg::REQ_REMOVE_AT: begin
                            n_rd_idx = in_pos + ONE_C;
                            n_left   = r_cnt - in_pos - ONE_C;
                            if (pos_cmp >= cnt_cmp) begin
                                n_st    = oil_pkg::ST_RANGE;
                                n_state = oil_pkg::S_DONE;
                            end
                        end
                        oil_pkg::REQ_FIND: begin
                            n_rd_idx = '0;
                            n_left   = r_cnt;
                        end
                        default: begin
                            n_state = oil_pkg::S_DONE;
                        end
                    endcase
                end
            end

            oil_pkg::S_WALK: begin
                // issue the next slot read
                if (r_left != '0) begin
                    mem_re     = 1'b1;
                    n_rd_idx   = walk_down ? (r_rd_idx - ONE_C) : (r_rd_idx + ONE_C);
                    n_left     = r_left - ONE_C;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx;
                end else begin
                    n_pend = 1'b0;
                end

                // consume the slot read issued in the previous cycle
                if (r_pend) begin
                    case (r_op)
                        oil_pkg::REQ_PUSH,
                        oil_pkg::REQ_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(r_pend_idx + ONE_C);
                            mem_wdata = mem_rdata;
                        end
                        oil_pkg::REQ_POP: begin
                            n_item = mem_rdata;
                        end
                        oil_pkg::REQ_REMOVE_ALL: begin
                            if (mem_rdata != r_val) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_keep[AW-1:0];
                                mem_wdata = mem_rdata;
                                n_keep    = r_keep + ONE_C;
                            end
                        end
                        oil_pkg::REQ_REMOVE_AT: begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(r_pend_idx - ONE_C);
                            mem_wdata = mem_rdata;
                        end
                        oil_pkg::REQ_FIND: begin
                            if (mem_rdata == r_val) begin
                                n_fnd   = 1'b1;
                                n_fpos  = r_pend_idx;
                                n_pend  = 1'b0;
                                n_left  = '0;
                                n_state = oil_pkg::S_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (r_left == '0) begin
                    // walk finished
                    n_state = oil_pkg::S_DONE;
                    case (r_op)
                        oil_pkg::REQ_PUSH,
                        oil_pkg::REQ_INSERT: begin
                            n_state = oil_pkg::S_TAIL;
                        end
                        oil_pkg::REQ_POP,
                        oil_pkg::REQ_REMOVE_AT: begin
                            n_cnt = r_cnt - ONE_C;
                        end
                        oil_pkg::REQ_REMOVE_ALL: begin
                            n_cnt = r_keep;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            oil_pkg::S_TAIL: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = r_val;
                n_cnt     = r_cnt + ONE_C;
                n_state   = oil_pkg::S_DONE;
            end

            oil_pkg::S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_st;
                    n_o_item   = r_item;
                    n_o_found  = r_fnd;
                    n_o_fpos   = r_fpos;
                    n_o_count  = r_cnt;
                    n_state    = oil_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = oil_pkg::S_IDLE;
            end
        endcase
    end

    assign out_ext  = {{oil_pkg::IN_ITEM_W{1'b0}}, r_o_item};
    assign fpos_ext = {{oil_pkg::FPOS_W{1'b0}}, r_o_fpos};
    assign cnt_ext  = {{oil_pkg::CNT_W{1'b0}}, r_o_count};

    assign o_valid          = r_ov;
    assign o_status         = r_o_status;
    assign o_item_out       = out_ext[oil_pkg::IN_ITEM_W-1:0];
    assign o_found          = r_o_found;
    assign o_found_position = fpos_ext[oil_pkg::FPOS_W-1:0];
    assign o_count_out      = cnt_ext[oil_pkg::CNT_W-1:0];

endmodule

### src/oil_mem.sv
// ----------------------------------------------------------------------------
// oil_mem
// slot store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module oil_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
